// ----- rtl/strs_pkg.sv -----
`default_nettype none

package strs_pkg;

    localparam int COUNT_W = 11;
    localparam int SLOT_W  = 10;
    localparam int VALUE_W = 32;
    localparam int RANK_W  = 11;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic [SLOT_W-1:0]         slot;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [RANK_W-1:0] rank;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMPTY
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/sorted_table_rank_search.sv -----
`default_nettype none

// channel   direction  handshake                    payload
// in        input      i_in_valid / o_in_stall      i_in  (mode, slot, value)
// out       output     o_out_valid / i_out_stall    o_out (found, rank)
// cfg       input      i_cfg_we                     i_cfg_wdata (entry_count)
//
// a load beat writes one table slot; a slot at or beyond the table depth is not written
// a query beat makes at most floor(log2(n))+1 probes for n searched entries:
// the single table read port carries one probe a cycle; an empty table
// answers not found without reading the table
// the result sits in an output register, so a new beat is taken while it waits
// synchronous active-low reset clears control state only, the table is not cleared

module sorted_table_rank_search
    import strs_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in_item           i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_item               o_out,
    input  wire logic               i_cfg_we,
    input  wire logic [COUNT_W-1:0] i_cfg_wdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IW = $clog2(TABLE_DEPTH + 1);
    localparam int NW = (IW > COUNT_W) ? IW : COUNT_W;

    t_state                     r_state, n_state;
    logic [IW-1:0]              r_lo, n_lo;
    logic [IW-1:0]              r_hi_ex, n_hi_ex;
    logic [AW-1:0]              r_mid, n_mid;
    logic signed [VALUE_W-1:0]  r_key, n_key;
    logic                       r_out_valid, n_out_valid;
    t_out_item                  r_out, n_out;
    logic [COUNT_W-1:0]         r_count;

    logic [NW-1:0]              count_ext;
    logic [IW-1:0]              n_entries;
    logic                       slot_ok;
    logic                       out_free;
    logic                       wr_en;
    logic [AW-1:0]              rd_addr;
    logic [VALUE_W-1:0]         rd_data;
    logic signed [VALUE_W-1:0]  probe;
    logic                       hit;
    logic [IW-1:0]              step_lo;
    logic [IW-1:0]              step_hi;

    // midpoint of [lo, hi_ex-1], rounding down
    function automatic logic [AW-1:0] mid_of(input logic [IW-1:0] lo,
                                             input logic [IW-1:0] hi_ex);
        logic [IW:0] s;
        s = {1'b0, lo} + {1'b0, hi_ex} - (IW+1)'(1);
        return AW'(s[IW:1]);
    endfunction

    strs_table_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_in.slot)),
        .i_wdata (i_in.value),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // searched range saturates at the table depth
    assign count_ext = NW'(r_count);
    assign n_entries = (count_ext > NW'(TABLE_DEPTH)) ? IW'(TABLE_DEPTH) : IW'(count_ext);
    assign slot_ok   = 32'(i_in.slot) < 32'(TABLE_DEPTH);
    assign out_free  = !r_out_valid || !i_out_stall;

    assign probe   = $signed(rd_data);
    assign hit     = (probe == r_key);
    assign step_lo = (probe < r_key) ? IW'(r_mid) + IW'(1) : r_lo;
    assign step_hi = (probe < r_key) ? r_hi_ex : IW'(r_mid);

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi_ex     = r_hi_ex;
        n_mid       = r_mid;
        n_key       = r_key;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        rd_addr     = r_mid;
        wr_en       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in.mode == MODE_LOAD) begin
                        wr_en = slot_ok;
                    end else begin
                        n_key   = i_in.value;
                        n_lo    = '0;
                        n_hi_ex = n_entries;
                        if (n_entries == '0) begin
                            n_state = ST_EMPTY;
                        end else begin
                            n_mid   = mid_of('0, n_entries);
                            rd_addr = n_mid;
                            n_state = ST_SEARCH;
                        end
                    end
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out.found = 1'b1;
                        n_out.rank  = RANK_W'((IW+1)'(r_mid) + (IW+1)'(1));
                        n_state     = ST_IDLE;
                    end
                end else if (step_lo >= step_hi) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out.found = 1'b0;
                        n_out.rank  = '0;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    n_lo    = step_lo;
                    n_hi_ex = step_hi;
                    n_mid   = mid_of(step_lo, step_hi);
                    rd_addr = n_mid;
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out.found = 1'b0;
                    n_out.rank  = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi_ex <= n_hi_ex;
        r_mid   <= n_mid;
        r_key   <= n_key;
        r_out   <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_range_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SEARCH |-> r_lo < r_hi_ex)
        else $error("search range empty while probing");

    a_mid_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SEARCH |-> (IW'(r_mid) >= r_lo) && (IW'(r_mid) < r_hi_ex))
        else $error("probe address outside search range");

    a_rank_matches_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.found && o_out.rank != '0) || (!o_out.found && o_out.rank == '0))
        else $error("rank disagrees with found flag");

    a_result_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_SEARCH || $past(r_state) == ST_EMPTY)
        else $error("result raised without a query in flight");
`endif

endmodule

`default_nettype wire

// ----- rtl/strs_table_ram.sv -----
`default_nettype none

module strs_table_ram
    import strs_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [AW-1:0]      i_waddr,
    input  wire logic [VALUE_W-1:0] i_wdata,
    input  wire logic [AW-1:0]      i_raddr,
    output logic      [VALUE_W-1:0] o_rdata
);

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
